>>> src/hqpt_pkg.sv
// hqpt_pkg: shared types and constants of the hall quadrature position tracker
// no dependencies; used by hqpt_step and the top level

package hqpt_pkg;

  localparam int unsigned WidthW = 14;
  localparam int unsigned PosW   = 16;
  localparam int unsigned CfgW   = 16;

  // number of mismatching samples before a new level is taken
  localparam logic [1:0] DEBOUNCE_COUNT = 2'd3;
  localparam logic [WidthW-1:0] STALL_RESET = 14'd15000;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_TRAVEL_DIR  = 2'd0,
    REG_POS_MAX     = 2'd1,
    REG_POS_MIN     = 2'd2,
    REG_STALL_LIMIT = 2'd3
  } cfg_reg_t;

  // configuration register set
  typedef struct packed {
    logic              travel_direction;
    logic [PosW-1:0]   position_max;
    logic [PosW-1:0]   position_min;
    logic [WidthW-1:0] stall_limit;
  } cfg_t;

  // tracker state carried from sample to sample
  typedef struct packed {
    logic              accepted_level;
    logic [1:0]        mismatch_count;
    logic [WidthW-1:0] interval_count;
    logic [WidthW-1:0] captured_width;
    logic              direction_bit;
    logic [PosW-1:0]   position_count;
  } state_t;

  // one result
  typedef struct packed {
    logic              edge_seen;
    logic              measured_direction;
    logic [WidthW-1:0] pulse_width;
    logic [PosW-1:0]   position;
    logic              stalled;
  } result_t;

endpackage

>>> src/hqpt_step.sv
// hqpt_step: next state and result of the tracker for one sensor sample
// depends on hqpt_pkg

module hqpt_step (
  input  hqpt_pkg::cfg_t    cfg,
  input  hqpt_pkg::state_t  state,
  input  logic              hall_a,
  input  logic              hall_b,
  output hqpt_pkg::state_t  state_nxt,
  output hqpt_pkg::result_t result
);

  logic                       stalled;
  logic [hqpt_pkg::WidthW-1:0] interval_inc;
  logic [1:0]                 mismatch_inc;
  logic                       edge_hit;
  logic                       dir_new;

  // interval counter, held once it reaches the stall limit
  always_comb begin
    stalled      = (state.interval_count >= cfg.stall_limit);
    interval_inc = stalled ? state.interval_count
                           : state.interval_count + hqpt_pkg::WidthW'(1);
  end

  // debounce of sensor a; the mismatch count is kept on a matching sample
  always_comb begin
    mismatch_inc = state.mismatch_count + 2'd1;
    edge_hit     = (hall_a != state.accepted_level)
                   && (mismatch_inc >= hqpt_pkg::DEBOUNCE_COUNT);
    dir_new      = hall_a ^ hall_b;
  end

  // state update
  always_comb begin
    state_nxt                = state;
    state_nxt.interval_count = interval_inc;
    if (hall_a != state.accepted_level) begin
      state_nxt.mismatch_count = mismatch_inc;
    end
    if (edge_hit) begin
      state_nxt.mismatch_count = 2'd0;
      state_nxt.direction_bit  = dir_new;
      state_nxt.captured_width = interval_inc;
      state_nxt.interval_count = '0;
      state_nxt.accepted_level = hall_a;
      if (dir_new != cfg.travel_direction) begin
        if (state.position_count < cfg.position_max) begin
          state_nxt.position_count = state.position_count + hqpt_pkg::PosW'(1);
        end
      end else begin
        if (state.position_count > cfg.position_min) begin
          state_nxt.position_count = state.position_count - hqpt_pkg::PosW'(1);
        end
      end
    end
  end

  // result fields
  always_comb begin
    result.edge_seen          = edge_hit;
    result.measured_direction = state_nxt.direction_bit;
    result.pulse_width        = state_nxt.captured_width;
    result.position           = state_nxt.position_count;
    result.stalled            = stalled;
  end

endmodule

>>> src/hall_quadrature_position_tracker.sv
// Hall quadrature position tracker, top level: config registers, state, result buffering
// depends on hqpt_pkg and hqpt_step
//
// Takes one sample of Hall sensors A and B per request and returns exactly one
// result per request. A new request is accepted every clock cycle while in_ready
// is high; the state update is combinational logic. A two-entry output buffer
// (output register plus skid register) holds the registered results and lets
// one further request be taken while a result waits, so in_ready only drops
// once both entries are full. Configuration writes take effect at the next clock
// edge and are meant to be made while the block is idle. Reset puts all counters
// and flags at zero and the registers at their defaults: travel direction 0,
// position bounds 0 to 65535, stall limit 15000.

module hall_quadrature_position_tracker (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // sensor samples
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_hall_a,
  input  logic        in_hall_b,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_edge_seen,
  output logic        out_measured_direction,
  output logic [13:0] out_pulse_width,
  output logic [15:0] out_position,
  output logic        out_stalled
);

  hqpt_pkg::cfg_t    cfg_r;
  hqpt_pkg::state_t  state_r;
  hqpt_pkg::state_t  state_nxt;
  hqpt_pkg::result_t result;
  hqpt_pkg::result_t out_data_r;
  hqpt_pkg::result_t skid_data_r;
  logic              out_valid_r;
  logic              skid_valid_r;
  logic              in_accept;
  logic              out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.travel_direction <= 1'b0;
      cfg_r.position_max     <= '1;
      cfg_r.position_min     <= '0;
      cfg_r.stall_limit      <= hqpt_pkg::STALL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        hqpt_pkg::REG_TRAVEL_DIR:  cfg_r.travel_direction <= cfg_wdata[0];
        hqpt_pkg::REG_POS_MAX:     cfg_r.position_max     <= cfg_wdata;
        hqpt_pkg::REG_POS_MIN:     cfg_r.position_min     <= cfg_wdata;
        hqpt_pkg::REG_STALL_LIMIT: cfg_r.stall_limit      <= cfg_wdata[hqpt_pkg::WidthW-1:0];
        default: ;
      endcase
    end
  end

  // per-sample logic
  hqpt_step u_step (
    .cfg       (cfg_r),
    .state     (state_r),
    .hall_a    (in_hall_a),
    .hall_b    (in_hall_b),
    .state_nxt (state_nxt),
    .result    (result)
  );

  assign in_ready  = !skid_valid_r;
  assign in_accept = in_valid && in_ready;
  assign out_free  = out_ready || !out_valid_r;

  // tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // output register and skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_accept) begin
        out_data_r <= result;
      end
    end else if (in_accept) begin
      skid_data_r <= result;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_edge_seen          = out_data_r.edge_seen;
  assign out_measured_direction = out_data_r.measured_direction;
  assign out_pulse_width        = out_data_r.pulse_width;
  assign out_position           = out_data_r.position;
  assign out_stalled            = out_data_r.stalled;

endmodule

>>> tb/testbench.sv
// testbench for hall_quadrature_position_tracker: debounce, direction, pulse width,
// stall flag and bounded position, checked result by result against an in-bench tracker
// depends on hqpt_pkg and the hall_quadrature_position_tracker rtl

module testbench;

  localparam int unsigned CycleLimit = 400000;

  // tracker prediction and the results still owed by the block
  class hall_track_board;
    hqpt_pkg::cfg_t                      regs;
    logic                                level;
    logic [1:0]                          misses;
    logic [hqpt_pkg::WidthW-1:0]         interval;
    logic [hqpt_pkg::WidthW-1:0]         width;
    logic                                dir;
    logic [hqpt_pkg::PosW-1:0]           pos;
    hqpt_pkg::result_t                   due_reports[$];
    int unsigned                         faults;
    int unsigned                         samples;
    int unsigned                         edges;
    int unsigned                         stalls;
    int unsigned                         checked;

    function new();
      regs.travel_direction = 1'b0;
      regs.position_max     = '1;
      regs.position_min     = '0;
      regs.stall_limit      = hqpt_pkg::STALL_RESET;
      level    = 1'b0;
      misses   = '0;
      interval = '0;
      width    = '0;
      dir      = 1'b0;
      pos      = '0;
      faults   = 0;
      samples  = 0;
      edges    = 0;
      stalls   = 0;
      checked  = 0;
    endfunction

    function void set_reg(hqpt_pkg::cfg_reg_t idx, logic [hqpt_pkg::CfgW-1:0] v);
      case (idx)
        hqpt_pkg::REG_TRAVEL_DIR:  regs.travel_direction = v[0];
        hqpt_pkg::REG_POS_MAX:     regs.position_max = v;
        hqpt_pkg::REG_POS_MIN:     regs.position_min = v;
        hqpt_pkg::REG_STALL_LIMIT: regs.stall_limit = v[hqpt_pkg::WidthW-1:0];
        default:                   ;
      endcase
    endfunction

    // one sensor sample: stall test and count first, then the debounced edge
    function void note_sample(logic a, logic b);
      hqpt_pkg::result_t r;
      r = '0;
      if (interval < regs.stall_limit) begin
        interval = interval + 1'b1;
      end else begin
        r.stalled = 1'b1;
        stalls++;
      end
      // mismatch count is kept across matching samples
      if (a != level) begin
        misses = misses + 2'd1;
        if (misses >= hqpt_pkg::DEBOUNCE_COUNT) begin
          misses      = '0;
          r.edge_seen = 1'b1;
          dir         = a ^ b;
          width       = interval;
          interval    = '0;
          if (dir != regs.travel_direction) begin
            if (pos < regs.position_max) pos = pos + 1'b1;
          end else if (pos > regs.position_min) begin
            pos = pos - 1'b1;
          end
          level = a;
          edges++;
        end
      end
      r.measured_direction = dir;
      r.pulse_width        = width;
      r.position           = pos;
      due_reports.push_back(r);
      samples++;
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want != got) begin
        faults++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_report(hqpt_pkg::result_t got);
      hqpt_pkg::result_t want;
      if (due_reports.size() == 0) begin
        faults++;
        $display("%0t: result with none outstanding, expected nothing actual position %0d",
                 $time, got.position);
        return;
      end
      want = due_reports.pop_front();
      checked++;
      check_field("edge_seen", 32'(want.edge_seen), 32'(got.edge_seen));
      check_field("measured_direction", 32'(want.measured_direction),
                  32'(got.measured_direction));
      check_field("pulse_width", 32'(want.pulse_width), 32'(got.pulse_width));
      check_field("position", 32'(want.position), 32'(got.position));
      check_field("stalled", 32'(want.stalled), 32'(got.stalled));
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_hall_a = 1'b0;
  logic        in_hall_b = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_edge_seen;
  logic        out_measured_direction;
  logic [13:0] out_pulse_width;
  logic [15:0] out_position;
  logic        out_stalled;

  hall_track_board board;
  int unsigned     cycles = 0;
  int unsigned     ready_left = 0;
  int unsigned     settings = 1;

  hall_quadrature_position_tracker i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_hall_a              (in_hall_a),
    .in_hall_b              (in_hall_b),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_edge_seen          (out_edge_seen),
    .out_measured_direction (out_measured_direction),
    .out_pulse_width        (out_pulse_width),
    .out_position           (out_position),
    .out_stalled            (out_stalled)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("hall_quadrature_position_tracker: mismatch");
      $finish;
    end
  end

  // receiver: short random stalls, now and then a long stretch always ready
  always @(posedge clk) begin
    if (ready_left == 0) begin
      if ($urandom_range(0, 15) == 0) begin
        out_ready  <= 1'b1;
        ready_left <= $urandom_range(50, 200);
      end else begin
        out_ready  <= ($urandom_range(0, 2) != 0);
        ready_left <= $urandom_range(0, 7);
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_report('{out_edge_seen, out_measured_direction, out_pulse_width,
                           out_position, out_stalled});
  end

  task automatic send_sample(logic a, logic b);
    in_valid  <= 1'b1;
    in_hall_a <= a;
    in_hall_b <= b;
    do @(posedge clk); while (!in_ready);
    board.note_sample(a, b);
  endtask

  task automatic idle_for(int unsigned n);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold requests back until every result is in
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (board.due_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(hqpt_pkg::cfg_reg_t idx, logic [hqpt_pkg::CfgW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    board.set_reg(idx, v);
  endtask

  task automatic configure(logic travel, logic [15:0] pmax, logic [15:0] pmin,
                           logic [13:0] stall);
    wait_for_drain();
    write_reg(hqpt_pkg::REG_TRAVEL_DIR, {15'd0, travel});
    write_reg(hqpt_pkg::REG_POS_MAX, pmax);
    write_reg(hqpt_pkg::REG_POS_MIN, pmin);
    write_reg(hqpt_pkg::REG_STALL_LIMIT, {2'd0, stall});
    cfg_we <= 1'b0;
    settings++;
  endtask

  // rotating motor: level runs on sensor a, b in quadrature, some bounce and noise
  task automatic run_motion(int unsigned count);
    int unsigned burst;
    int unsigned run_left;
    int unsigned i;
    logic        lvl;
    logic        heading;
    logic        a;
    logic        b;
    burst    = $urandom_range(1, 40);
    run_left = 0;
    lvl      = board.level;
    heading  = 1'($urandom_range(0, 1));
    for (i = 0; i < count; i++) begin
      if (run_left == 0) begin
        lvl = ~lvl;
        case ($urandom_range(0, 19))
          0, 1:    run_left = $urandom_range(1, 2);
          2:       run_left = $urandom_range(20, 300);
          default: run_left = $urandom_range(3, 12);
        endcase
        if ($urandom_range(0, 7) == 0) heading = ~heading;
      end
      run_left = run_left - 1;
      a = lvl;
      b = lvl ^ heading;
      if ($urandom_range(0, 9) == 0) a = ~a;
      if ($urandom_range(0, 9) == 0) b = ~b;
      send_sample(a, b);
      burst = burst - 1;
      if (burst == 0) begin
        idle_for($urandom_range(0, 6));
        burst = $urandom_range(1, 40);
      end
    end
  endtask

  // stimulus
  initial begin
    logic [1:0]  walk [20];
    int unsigned k;
    walk = '{2'b00, 2'b00, 2'b10, 2'b01, 2'b11, 2'b11,
             2'b01, 2'b01, 2'b01, 2'b10, 2'b10, 2'b10,
             2'b00, 2'b00, 2'b00, 2'b11, 2'b01, 2'b11, 2'b11, 2'b00};
    board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: match, mismatch then match, edges both ways, floor at zero
    for (k = 0; k < 20; k++) send_sample(walk[k][1], walk[k][0]);

    // widest stall limit, narrow position window; pause halfway until drained
    configure(1'b1, 16'd16, 16'd4, 14'd16383);
    run_motion(150);
    wait_for_drain();
    run_motion(150);

    // smallest nonzero stall limit
    configure(1'b0, 16'hFFFF, 16'd0, 14'd1);
    run_motion(200);

    // stall limit zero: never counts
    configure(1'b1, 16'hFFFF, 16'd0, 14'd0);
    run_motion(100);

    // limit lowered beneath a running count
    configure(1'b0, 16'hFFFF, 16'd0, 14'd1000);
    for (k = 0; k < 60; k++) send_sample(board.level, 1'($urandom_range(0, 1)));
    configure(1'b0, 16'hFFFF, 16'd0, 14'd20);
    run_motion(200);

    // lower bound above upper bound
    configure(1'b0, 16'd5, 16'd40, 14'd25);
    run_motion(200);
    configure(1'b1, 16'd0, 16'hFFFF, 14'd30);
    run_motion(150);

    for (k = 0; k < 4; k++) begin
      configure(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 200)), 14'($urandom_range(1, 60)));
      run_motion(120);
    end

    wait_for_drain();
    repeat (4) @(posedge clk);
    if (board.due_reports.size() != 0) begin
      board.faults++;
      $display("%0t: %0d results never arrived", $time, board.due_reports.size());
    end
    $display("covered %0d samples under %0d register settings, %0d results checked",
             board.samples, settings, board.checked);
    $display("%0d debounced edges accepted, %0d samples with the stall flag set",
             board.edges, board.stalls);
    if (board.faults == 0) begin
      $display("hall_quadrature_position_tracker: match");
    end else begin
      $display("hall_quadrature_position_tracker: mismatch");
    end
    $finish;
  end

endmodule
